// File: sv/arp_pkg.sv
package arp_pkg;
	localparam int CacheEntriesDef = 16;

	localparam logic [1:0] ActRecv = 2'd0;
	localparam logic [1:0] ActLookup = 2'd1;
	localparam logic [1:0] ActTick = 2'd2;

	localparam logic [2:0] StIgnored = 3'd0;
	localparam logic [2:0] StReply = 3'd1;
	localparam logic [2:0] StRequest = 3'd2;
	localparam logic [2:0] StHit = 3'd3;
	localparam logic [2:0] StCached = 3'd4;
	localparam logic [2:0] StMalformed = 3'd5;
	localparam logic [2:0] StUnknown = 3'd6;
	localparam logic [2:0] StTick = 3'd7;

	localparam logic [1:0] OpNone = 2'd0;
	localparam logic [1:0] OpRequest = 2'd1;
	localparam logic [1:0] OpReply = 2'd2;

	localparam logic [1:0] CfgOwnMac = 2'd0;
	localparam logic [1:0] CfgNetwork = 2'd1;
	localparam logic [1:0] CfgMask = 2'd2;
	localparam logic [1:0] CfgTtl = 2'd3;

	localparam logic [15:0] HwEthernet = 16'h0001;
	localparam logic [15:0] ProtoIpv4 = 16'h0800;
	localparam logic [7:0] HwLenEth = 8'd6;
	localparam logic [7:0] ProtoLenIp = 8'd4;
	localparam logic [15:0] MinLength = 16'd28;
	localparam logic [15:0] ArpOpRequest = 16'd1;
	localparam logic [15:0] ArpOpReply = 16'd2;
	localparam logic [47:0] Broadcast = 48'hFFFF_FFFF_FFFF;

	// classified job handed from front to back
	typedef enum logic [2:0] {
		JobMalformed, JobUnknown, JobIgnore, JobReply, JobStore, JobLookup, JobTick
	} job_kind_t;

	typedef struct packed {
		job_kind_t kind;
		logic [47:0] mac;
		logic [31:0] ip;
		logic [31:0] ip2;
	} job_t;

	typedef struct packed {
		logic [2:0] status;
		logic [1:0] tx_opcode;
		logic [47:0] tx_sender_mac;
		logic [31:0] tx_sender_ip;
		logic [47:0] tx_target_mac;
		logic [31:0] tx_target_ip;
		logic [47:0] tx_dest_mac;
		logic [47:0] resolved_mac;
	} result_t;
endpackage

// File: sv/arp_responder_and_cache_top.sv
// back end states: Idle, Scan (store and lookup only, entry by entry), Finish, Emit
// the back end takes a new item only in Idle, after the last result has been taken
// a two-deep queue after the classifier takes items while the back end scans or holds a result
// reset: arst_n clears cache valid bits, seconds counter and registers (ttl to 60) at once
module arp_responder_and_cache_top import arp_pkg::*; #(
	parameter int CACHE_ENTRIES = CacheEntriesDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// action, payload_length, hw_type, proto_type, hw_len, proto_len, op_code,
	// src_mac, src_ip, dst_ip, query_ip (226 bits, padded to 232)
	input  logic [231:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// status, tx_opcode, tx_sender_mac, tx_sender_ip, tx_target_mac, tx_target_ip,
	// tx_dest_mac, resolved_mac (261 bits, padded to 264)
	output logic [263:0] m_axis_tdata,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [47:0] cfg_data
);
	logic [47:0] own_mac_q;
	logic [31:0] net_q, mask_q;
	logic [15:0] ttl_q;
	logic job_valid, job_ready;
	job_t job;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q <= '0;
			net_q <= '0;
			mask_q <= '0;
			ttl_q <= 16'd60;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgOwnMac: own_mac_q <= cfg_data;
				CfgNetwork: net_q <= cfg_data[31:0];
				CfgMask: mask_q <= cfg_data[31:0];
				CfgTtl: ttl_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	arp_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.action(s_axis_tdata[1:0]),
		.payload_length(s_axis_tdata[17:2]),
		.hw_type(s_axis_tdata[33:18]),
		.proto_type(s_axis_tdata[49:34]),
		.hw_len(s_axis_tdata[57:50]),
		.proto_len(s_axis_tdata[65:58]),
		.op_code(s_axis_tdata[81:66]),
		.src_mac(s_axis_tdata[129:82]),
		.src_ip(s_axis_tdata[161:130]),
		.dst_ip(s_axis_tdata[193:162]),
		.query_ip(s_axis_tdata[225:194]),
		.subnet_network(net_q), .subnet_mask(mask_q),
		.job_valid, .job_ready, .job
	);

	arp_back #(.CacheEntries(CACHE_ENTRIES)) u_back (
		.clk, .arst_n, .job_valid, .job_ready, .job,
		.own_mac(own_mac_q), .subnet_network(net_q), .cache_ttl(ttl_q),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
	);

	assign m_axis_tdata = {3'd0, res.resolved_mac, res.tx_dest_mac, res.tx_target_ip,
		res.tx_target_mac, res.tx_sender_ip, res.tx_sender_mac, res.tx_opcode, res.status};
endmodule

// File: sv/arp_front.sv
module arp_front import arp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] action,
	input  logic [15:0] payload_length,
	input  logic [15:0] hw_type,
	input  logic [15:0] proto_type,
	input  logic [7:0] hw_len,
	input  logic [7:0] proto_len,
	input  logic [15:0] op_code,
	input  logic [47:0] src_mac,
	input  logic [31:0] src_ip,
	input  logic [31:0] dst_ip,
	input  logic [31:0] query_ip,
	input  logic [31:0] subnet_network,
	input  logic [31:0] subnet_mask,
	output logic job_valid,
	input  logic job_ready,
	output job_t job
);
	// two-entry queue
	job_t q_q [2];
	logic [1:0] cnt_q;
	logic rd_q, wr_q;
	job_t cls;

	always_comb begin
		cls.kind = JobIgnore;
		cls.mac = src_mac;
		cls.ip = src_ip;
		cls.ip2 = dst_ip;
		case (action)
			ActRecv: begin
				if (payload_length < MinLength || hw_type != HwEthernet ||
				    proto_type != ProtoIpv4 || hw_len != HwLenEth || proto_len != ProtoLenIp)
					cls.kind = JobMalformed;
				else if (op_code == ArpOpRequest)
					cls.kind = ((dst_ip & subnet_mask) == (subnet_network & subnet_mask))
						? JobReply : JobIgnore;
				else if (op_code == ArpOpReply)
					cls.kind = JobStore;
				else
					cls.kind = JobUnknown;
			end
			ActLookup: begin
				cls.kind = JobLookup;
				cls.ip = query_ip;
			end
			ActTick: cls.kind = JobTick;
			default: cls.kind = JobIgnore;
		endcase
	end

	assign in_ready = cnt_q != 2'd2;
	assign job_valid = cnt_q != 2'd0;
	assign job = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) q_q[wr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) wr_q <= ~wr_q;
			if (job_valid && job_ready) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, in_valid && in_ready} - {1'b0, job_valid && job_ready};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue overfilled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> (rd_q == wr_q)) else $error("queue pointers apart when empty");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> (rd_q == wr_q)) else $error("queue pointers apart when full");
endmodule

// File: sv/arp_back.sv
module arp_back import arp_pkg::*; #(
	parameter int CacheEntries = CacheEntriesDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	output logic job_ready,
	input  job_t job,
	input  logic [47:0] own_mac,
	input  logic [31:0] subnet_network,
	input  logic [15:0] cache_ttl,
	output logic res_valid,
	input  logic res_ready,
	output result_t res
);
	localparam int IW = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;
	localparam int CW = $clog2(CacheEntries + 1);

	typedef enum logic [1:0] {Idle, Scan, Finish, Emit} state_t;

	state_t state_q;
	job_t job_q;
	logic [CacheEntries-1:0] valid_q;
	logic [31:0] ip_mem [CacheEntries];
	logic [47:0] mac_mem [CacheEntries];
	logic [31:0] stamp_mem [CacheEntries];
	logic [31:0] seconds_q;
	logic [CW-1:0] idx_q;
	logic found_q, free_q;
	logic [IW-1:0] found_idx_q, free_idx_q, old_idx_q;
	logic [31:0] old_age_q, found_age_q;
	logic [47:0] found_mac_q;
	logic [IW-1:0] slot;
	logic [IW-1:0] cur;
	logic [31:0] age;
	result_t res_q;
	result_t res_d;

	assign cur = idx_q[IW-1:0];
	assign age = seconds_q - stamp_mem[cur];
	assign slot = found_q ? found_idx_q : (free_q ? free_idx_q : old_idx_q);
	assign job_ready = state_q == Idle;
	assign res_valid = state_q == Emit;
	assign res = res_q;

	always_comb begin
		res_d = '0;
		case (job_q.kind)
			JobMalformed: res_d.status = StMalformed;
			JobUnknown: res_d.status = StUnknown;
			JobReply: begin
				res_d.status = StReply;
				res_d.tx_opcode = OpReply;
				res_d.tx_sender_mac = own_mac;
				res_d.tx_sender_ip = job_q.ip2;
				res_d.tx_target_mac = job_q.mac;
				res_d.tx_target_ip = job_q.ip;
				res_d.tx_dest_mac = job_q.mac;
			end
			JobStore: res_d.status = StCached;
			JobLookup: begin
				if (found_q && found_age_q <= {16'd0, cache_ttl}) begin
					res_d.status = StHit;
					res_d.resolved_mac = found_mac_q;
				end else begin
					res_d.status = StRequest;
					res_d.tx_opcode = OpRequest;
					res_d.tx_sender_mac = own_mac;
					res_d.tx_sender_ip = subnet_network;
					res_d.tx_target_mac = Broadcast;
					res_d.tx_target_ip = job_q.ip;
					res_d.tx_dest_mac = Broadcast;
				end
			end
			JobTick: res_d.status = StTick;
			default: res_d.status = StIgnored;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == Finish && job_q.kind == JobStore) begin
			ip_mem[slot] <= job_q.ip;
			mac_mem[slot] <= job_q.mac;
			stamp_mem[slot] <= seconds_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= Idle;
			valid_q <= '0;
			seconds_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0;
			free_q <= 1'b0;
			found_idx_q <= '0;
			free_idx_q <= '0;
			old_idx_q <= '0;
			old_age_q <= '0;
			found_age_q <= '0;
			found_mac_q <= '0;
			job_q <= '0;
			res_q <= '0;
		end else begin
			case (state_q)
				Idle: if (job_valid) begin
					job_q <= job;
					idx_q <= '0;
					found_q <= 1'b0;
					free_q <= 1'b0;
					old_idx_q <= '0;
					old_age_q <= '0;
					state_q <= (job.kind == JobStore || job.kind == JobLookup) ? Scan : Finish;
				end
				Scan: begin
					// one entry a cycle: match, lowest free slot, oldest entry
					if (valid_q[cur] && ip_mem[cur] == job_q.ip && !found_q) begin
						found_q <= 1'b1;
						found_idx_q <= cur;
						found_age_q <= age;
						found_mac_q <= mac_mem[cur];
					end
					if (!valid_q[cur] && !free_q) begin
						free_q <= 1'b1;
						free_idx_q <= cur;
					end
					if (idx_q == '0 || age > old_age_q) begin
						old_idx_q <= cur;
						old_age_q <= age;
					end
					if (idx_q == CW'(CacheEntries - 1)) state_q <= Finish;
					idx_q <= idx_q + 1'b1;
				end
				Finish: begin
					res_q <= res_d;
					if (job_q.kind == JobStore) valid_q[slot] <= 1'b1;
					if (job_q.kind == JobTick) seconds_q <= seconds_q + 32'd1;
					state_q <= Emit;
				end
				Emit: if (res_ready) state_q <= Idle;
				default: state_q <= Idle;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == Emit && !res_ready) |=> state_q == Emit) else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == Scan) |-> idx_q < CW'(CacheEntries)) else $error("scan index overrun");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != Finish) |=> $stable(seconds_q)) else $error("clock moved outside finish");
endmodule

// File: bench/arp_responder_and_cache_top_tb.sv
module arp_responder_and_cache_top_tb;
	import arp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CACHE_ENTRIES = 16;
	localparam logic [1:0] ActUnused = 2'd3;
	localparam int PoolSize = 24;

	typedef struct {
		logic [1:0] action;
		logic [15:0] payload_length;
		logic [15:0] hw_type;
		logic [15:0] proto_type;
		logic [7:0] hw_len;
		logic [7:0] proto_len;
		logic [15:0] op_code;
		logic [47:0] src_mac;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [31:0] query_ip;
	} arp_item_t;

	typedef struct {
		arp_item_t it;
		bit typed;
		result_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [231:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [263:0] m_axis_tdata;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [47:0] cfg_data;

	arp_responder_and_cache_top #(.CACHE_ENTRIES(CACHE_ENTRIES)) dut (.*);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// predictor copy of registers and cache
	logic [47:0] own_mac_q;
	logic [31:0] network_q;
	logic [31:0] mask_q;
	logic [15:0] ttl_q;
	bit cache_valid[CACHE_ENTRIES];
	logic [31:0] cache_ip[CACHE_ENTRIES];
	logic [47:0] cache_mac[CACHE_ENTRIES];
	logic [31:0] cache_stamp[CACHE_ENTRIES];
	logic [31:0] seconds_q;

	result_t pending_results[$];
	int mismatches;
	int send_idle_pct;
	int recv_stall_pct;

	function automatic int cache_find(logic [31:0] ip);
		for (int i = 0; i < CACHE_ENTRIES; i++)
			if (cache_valid[i] && cache_ip[i] == ip)
				return i;
		return -1;
	endfunction

	function automatic void cache_store(logic [31:0] ip, logic [47:0] mac);
		int slot;
		logic [31:0] oldest;
		slot = cache_find(ip);
		if (slot < 0) begin
			for (int i = 0; i < CACHE_ENTRIES; i++)
				if (!cache_valid[i] && slot < 0)
					slot = i;
		end
		if (slot < 0) begin
			// full: evict the oldest, lowest index on a tie
			slot = 0;
			oldest = seconds_q - cache_stamp[0];
			for (int i = 1; i < CACHE_ENTRIES; i++)
				if (seconds_q - cache_stamp[i] > oldest) begin
					slot = i;
					oldest = seconds_q - cache_stamp[i];
				end
		end
		cache_valid[slot] = 1'b1;
		cache_ip[slot] = ip;
		cache_mac[slot] = mac;
		cache_stamp[slot] = seconds_q;
	endfunction

	function automatic result_t arp_predict(arp_item_t it);
		result_t r;
		int k;
		r = '0;
		case (it.action)
			ActRecv: begin
				if (it.payload_length < MinLength || it.hw_type != HwEthernet
						|| it.proto_type != ProtoIpv4 || it.hw_len != HwLenEth
						|| it.proto_len != ProtoLenIp) begin
					r.status = StMalformed;
				end else if (it.op_code == ArpOpRequest) begin
					if ((it.dst_ip & mask_q) == (network_q & mask_q)) begin
						r.status = StReply;
						r.tx_opcode = OpReply;
						r.tx_sender_mac = own_mac_q;
						r.tx_sender_ip = it.dst_ip;
						r.tx_target_mac = it.src_mac;
						r.tx_target_ip = it.src_ip;
						r.tx_dest_mac = it.src_mac;
					end
				end else if (it.op_code == ArpOpReply) begin
					cache_store(it.src_ip, it.src_mac);
					r.status = StCached;
				end else begin
					r.status = StUnknown;
				end
			end
			ActLookup: begin
				k = cache_find(it.query_ip);
				if (k >= 0 && seconds_q - cache_stamp[k] <= {16'd0, ttl_q}) begin
					r.status = StHit;
					r.resolved_mac = cache_mac[k];
				end else begin
					// sender ip is the network register as is, not masked
					r.status = StRequest;
					r.tx_opcode = OpRequest;
					r.tx_sender_mac = own_mac_q;
					r.tx_sender_ip = network_q;
					r.tx_target_mac = Broadcast;
					r.tx_target_ip = it.query_ip;
					r.tx_dest_mac = Broadcast;
				end
			end
			ActTick: begin
				seconds_q = seconds_q + 32'd1;
				r.status = StTick;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [231:0] pack_item(arp_item_t it);
		return {6'd0, it.query_ip, it.dst_ip, it.src_ip, it.src_mac, it.op_code,
			it.proto_len, it.hw_len, it.proto_type, it.hw_type, it.payload_length,
			it.action};
	endfunction

	function automatic result_t unpack_result(logic [263:0] d);
		result_t r;
		r.status = d[2:0];
		r.tx_opcode = d[4:3];
		r.tx_sender_mac = d[52:5];
		r.tx_sender_ip = d[84:53];
		r.tx_target_mac = d[132:85];
		r.tx_target_ip = d[164:133];
		r.tx_dest_mac = d[212:165];
		r.resolved_mac = d[260:213];
		return r;
	endfunction

	function automatic arp_item_t arp_frame(logic [15:0] op, logic [31:0] sip,
			logic [31:0] dip, logic [47:0] smac);
		arp_item_t it;
		it.action = ActRecv;
		it.payload_length = MinLength;
		it.hw_type = HwEthernet;
		it.proto_type = ProtoIpv4;
		it.hw_len = HwLenEth;
		it.proto_len = ProtoLenIp;
		it.op_code = op;
		it.src_mac = smac;
		it.src_ip = sip;
		it.dst_ip = dip;
		it.query_ip = '0;
		return it;
	endfunction

	function automatic arp_item_t plain_item(logic [1:0] act, logic [31:0] qip);
		arp_item_t it;
		it = arp_frame(16'd0, '0, '0, '0);
		it.action = act;
		it.payload_length = '0;
		it.hw_type = '0;
		it.proto_type = '0;
		it.hw_len = '0;
		it.proto_len = '0;
		it.query_ip = qip;
		return it;
	endfunction

	function automatic logic [47:0] rand_mac();
		return 48'({$urandom(), $urandom()});
	endfunction

	function automatic logic [31:0] pool_ip();
		return (network_q & mask_q) | 32'($urandom_range(0, PoolSize - 1));
	endfunction

	function automatic arp_item_t rand_item();
		arp_item_t it;
		int r;
		logic [31:0] dip;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			// noise over the full width of every field
			it.action = 2'($urandom());
			it.payload_length = 16'($urandom());
			it.hw_type = 16'($urandom());
			it.proto_type = 16'($urandom());
			it.hw_len = 8'($urandom());
			it.proto_len = 8'($urandom());
			it.op_code = 16'($urandom());
			it.src_mac = rand_mac();
			it.src_ip = $urandom();
			it.dst_ip = $urandom();
			it.query_ip = $urandom();
		end else if (r < 58) begin
			dip = ($urandom_range(0, 3) != 0) ? ((network_q & mask_q) | ($urandom() & ~mask_q))
				: $urandom();
			r = $urandom_range(0, 99);
			it = arp_frame(r < 60 ? ArpOpReply : r < 90 ? ArpOpRequest : 16'($urandom()),
				$urandom_range(0, 9) != 0 ? pool_ip() : $urandom(), dip, rand_mac());
			if ($urandom_range(0, 3) == 0)
				it.payload_length = 16'($urandom_range(28, 65535));
			it.query_ip = $urandom();
			case ($urandom_range(0, 19))
				0: it.payload_length = 16'($urandom_range(0, 27));
				1: it.hw_type = 16'($urandom());
				2: it.proto_type = 16'($urandom());
				3: it.hw_len = 8'($urandom());
				4: it.proto_len = 8'($urandom());
				default: ;
			endcase
		end else if (r < 82) begin
			it = plain_item(ActLookup, $urandom_range(0, 9) != 0 ? pool_ip() : $urandom());
		end else begin
			it = plain_item(ActTick, '0);
		end
		return it;
	endfunction

	task automatic drive_item(arp_item_t it, bit typed, result_t res);
		result_t p;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pack_item(it);
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		p = arp_predict(it);
		pending_results.push_back(typed ? res : p);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [47:0] val);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (CACHE_ENTRIES + 8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CfgOwnMac: own_mac_q = val;
			CfgNetwork: network_q = val[31:0];
			CfgMask: mask_q = val[31:0];
			CfgTtl: ttl_q = val[15:0];
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = unpack_result(m_axis_tdata);
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %h", got);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %h got %h", want, got);
					end
				end
			end
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		stim_row_t rows[$];
		stim_row_t row;
		arp_item_t bad;
		int phase;

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CfgOwnMac;
		cfg_data = '0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		own_mac_q = '0;
		network_q = '0;
		mask_q = '0;
		ttl_q = 16'd60;
		seconds_q = '0;
		foreach (cache_valid[i])
			cache_valid[i] = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// right after reset: ttl 60, everything in subnet
		drive_item(arp_frame(ArpOpReply, 32'h0A000001, '0, 48'h0000_0000_0001), 1'b0, '0);
		drive_item(plain_item(ActLookup, 32'h0A000001), 1'b0, '0);

		write_reg(CfgOwnMac, 48'hFFFF_FFFF_FFFF);
		write_reg(CfgNetwork, 48'h0000_C0A8_0100);
		write_reg(CfgMask, 48'h0000_FFFF_FF00);
		write_reg(CfgTtl, 48'd2);

		row.typed = 1'b1;
		row.res = '0;
		row.res.status = StTick;
		row.it = plain_item(ActTick, '0);
		rows.push_back(row);
		row.res.status = StIgnored;
		row.it = plain_item(ActUnused, 32'hFFFF_FFFF);
		row.it.payload_length = 16'hFFFF;
		row.it.src_mac = 48'hFFFF_FFFF_FFFF;
		rows.push_back(row);
		row.res.status = StMalformed;
		for (int i = 0; i < 5; i++) begin
			bad = arp_frame(ArpOpRequest, 32'hC0A80102, 32'hC0A80101, 48'h1);
			case (i)
				0: bad.payload_length = 16'd27;
				1: bad.hw_type = 16'd2;
				2: bad.proto_type = 16'h86DD;
				3: bad.hw_len = 8'd5;
				default: bad.proto_len = 8'hFF;
			endcase
			row.it = bad;
			rows.push_back(row);
		end
		row.res.status = StUnknown;
		row.it = arp_frame(16'd3, 32'hC0A80102, 32'hC0A80101, 48'h1);
		rows.push_back(row);
		row.it = arp_frame(16'hFFFF, '0, '0, '0);
		rows.push_back(row);
		// request outside the subnet emits only a result with status ignored
		row.res.status = StIgnored;
		row.it = arp_frame(ArpOpRequest, 32'hC0A80102, 32'hC0A80201, 48'h1);
		rows.push_back(row);
		row.res.status = StCached;
		row.it = arp_frame(ArpOpReply, 32'hC0A80105, 32'h0, 48'h0);
		rows.push_back(row);
		row.typed = 1'b0;
		row.it = arp_frame(ArpOpRequest, 32'hFFFF_FFFF, 32'hC0A801FF, 48'hFFFF_FFFF_FFFF);
		rows.push_back(row);
		row.it = plain_item(ActLookup, 32'hC0A80105);
		rows.push_back(row);
		row.it = plain_item(ActLookup, 32'h0);
		rows.push_back(row);
		for (int i = 0; i < 3; i++) begin
			row.it = plain_item(ActTick, '0);
			rows.push_back(row);
		end
		// entry now older than ttl
		row.it = plain_item(ActLookup, 32'hC0A80105);
		rows.push_back(row);
		row.it = arp_frame(ArpOpReply, 32'hC0A80105, 32'h0, 48'hA5A5_5A5A_0F0F);
		row.it.payload_length = 16'hFFFF;
		rows.push_back(row);
		row.it = plain_item(ActLookup, 32'hC0A80105);
		rows.push_back(row);

		foreach (rows[i])
			drive_item(rows[i].it, rows[i].typed, rows[i].res);

		for (phase = 0; phase < 4; phase++) begin
			send_idle_pct = 0;
			recv_stall_pct = 0;
			s_axis_tvalid <= 1'b0;
			case (phase)
				0: begin
					write_reg(CfgOwnMac, rand_mac());
					write_reg(CfgTtl, 48'd3);
				end
				1: begin
					write_reg(CfgOwnMac, 48'd0);
					write_reg(CfgNetwork, 48'h0000_FFFF_FFFF);
					write_reg(CfgMask, 48'd0);
					write_reg(CfgTtl, 48'd0);
				end
				2: begin
					write_reg(CfgNetwork, {16'd0, $urandom()});
					write_reg(CfgMask, 48'h0000_FFFF_FF00);
					write_reg(CfgTtl, 48'hFFFF);
				end
				default: begin
					write_reg(CfgOwnMac, rand_mac());
					write_reg(CfgMask, 48'h0000_FFFF_FFFF);
					write_reg(CfgTtl, 48'd5);
				end
			endcase
			send_idle_pct = (phase == 1) ? 81 : (phase == 3) ? 25 : 0;
			recv_stall_pct = (phase == 2) ? 81 : (phase == 3) ? 25 : 0;
			for (int n = 0; n < 200; n++)
				drive_item(rand_item(), 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;
		recv_stall_pct = 0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (CACHE_ENTRIES + 10) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
